FILE: rtl/core/lhbp_pkg.sv
// shared constants, string tables, types and match helpers of the header block parser
package lhbp_pkg;

	localparam int MAX_BLOCK_BYTES = 4096;
	localparam int POS_W = $clog2(MAX_BLOCK_BYTES + 1);
	localparam int ACC_W = $clog2(4 * MAX_BLOCK_BYTES);
	localparam logic [ACC_W-1:0] ACC_CAP = ACC_W'(4 * MAX_BLOCK_BYTES - 1);
	localparam int OFF_W = 12;
	localparam int LEN_W = 13;

	localparam logic [7:0] PREFIX_MASK = 8'he0;
	localparam logic [7:0] PREFIX_CODE = 8'h20;
	localparam logic [7:0] VARINT_MASK = 8'h3f;

	// name table indexes
	localparam int NUM_NAMES = 7;
	localparam int NM_METHOD = 0;
	localparam int NM_PROTOCOL = 1;
	localparam int NM_SCHEME = 2;
	localparam int NM_PATH = 3;
	localparam int NM_AUTHORITY = 4;
	localparam int NM_ORIGIN = 5;
	localparam int NM_STATUS = 6;
	localparam int NAME_MAX = 10;

	// value table indexes
	localparam int NUM_VALUES = 4;
	localparam int VL_CONNECT = 0;
	localparam int VL_WEBTRANSPORT = 1;
	localparam int VL_HTTPS = 2;
	localparam int VL_OK = 3;
	localparam int VALUE_MAX = 12;

	localparam int NUM_CAPS = 3;

	// strings are right aligned, first character in the highest used byte
	localparam logic [NAME_MAX*8-1:0] NAME_STR [NUM_NAMES] = '{
		":method", ":protocol", ":scheme", ":path", ":authority", "origin", ":status"
	};
	localparam int NAME_SIZE [NUM_NAMES] = '{7, 9, 7, 5, 10, 6, 7};

	localparam logic [VALUE_MAX*8-1:0] VALUE_STR [NUM_VALUES] = '{
		"CONNECT", "webtransport", "https", "200"
	};
	localparam int VALUE_SIZE [NUM_VALUES] = '{7, 12, 5, 3};

	typedef struct packed {
		logic [7:0] block_byte;
		logic       last;
	} lhbp_item_t;

	typedef struct packed {
		logic             rejected;
		logic             method_is_connect;
		logic             protocol_is_webtransport;
		logic             scheme_is_https;
		logic             status_is_ok;
		logic [2:0]       present_mask;
		logic [OFF_W-1:0] path_start;
		logic [LEN_W-1:0] path_length;
		logic [OFF_W-1:0] authority_start;
		logic [LEN_W-1:0] authority_length;
		logic [OFF_W-1:0] origin_start;
		logic [LEN_W-1:0] origin_length;
	} lhbp_result_t;

	function automatic logic name_hit(input int k, input logic [POS_W-1:0] idx,
			input logic [7:0] b);
		int sh;
		logic [NAME_MAX*8-1:0] s;
		if (int'(idx) >= NAME_SIZE[k]) return 1'b0;
		s = NAME_STR[k];
		sh = (NAME_SIZE[k] - 1 - int'(idx)) * 8;
		return s[sh +: 8] == b;
	endfunction

	function automatic logic value_hit(input int k, input logic [POS_W-1:0] idx,
			input logic [7:0] b);
		int sh;
		logic [VALUE_MAX*8-1:0] s;
		if (int'(idx) >= VALUE_SIZE[k]) return 1'b0;
		s = VALUE_STR[k];
		sh = (VALUE_SIZE[k] - 1 - int'(idx)) * 8;
		return s[sh +: 8] == b;
	endfunction

endpackage

FILE: rtl/core/literal_header_block_parser_top.sv
// Header block parser: takes one byte of a header block per transfer and returns one verdict
// per block. The input channel (in_valid, in_stall, block_byte, end_of_block) carries the
// block in order; end_of_block marks its last byte. The output channel (out_valid, out_stall
// and the result fields) carries one result per block: rejected, the four value flags,
// present_mask and the start and length of the path, authority and origin values.
// Throughput is one byte per cycle while in_stall is low; each byte is parsed combinationally
// between the input register and the parse state registers, with small compares against the
// name and value tables and a 14-bit varint accumulator.
// The final byte is held in the input register, parsed, and its result written to the output
// register, which drives out_valid.
// When the receiver stalls, the result holds in the output register and bytes keep flowing;
// in_stall rises only when the next block's final byte reaches the input register while the
// previous result is still held.
// Reset (arst_n low) puts the parser at the start of a block and drops any pending byte or
// result; blocks are parsed independently, the parser restarts after each final byte.
module literal_header_block_parser_top
	import lhbp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       block_byte,
	input  logic             end_of_block,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             rejected,
	output logic             method_is_connect,
	output logic             protocol_is_webtransport,
	output logic             scheme_is_https,
	output logic             status_is_ok,
	output logic [2:0]       present_mask,
	output logic [OFF_W-1:0] path_start,
	output logic [LEN_W-1:0] path_length,
	output logic [OFF_W-1:0] authority_start,
	output logic [LEN_W-1:0] authority_length,
	output logic [OFF_W-1:0] origin_start,
	output logic [LEN_W-1:0] origin_length
);

	lhbp_item_t   in_item;
	lhbp_item_t   item_s1;
	logic         take;
	logic         out_busy;
	logic         push;
	lhbp_result_t res;
	lhbp_result_t out_res;

	assign in_item.block_byte = block_byte;
	assign in_item.last = end_of_block;

	lhbp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.out_busy (out_busy),
		.in_stall (in_stall),
		.take     (take),
		.item_s1  (item_s1)
	);

	lhbp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.push   (push),
		.res    (res)
	);

	lhbp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_busy  (out_busy),
		.out_res   (out_res)
	);

	assign rejected = out_res.rejected;
	assign method_is_connect = out_res.method_is_connect;
	assign protocol_is_webtransport = out_res.protocol_is_webtransport;
	assign scheme_is_https = out_res.scheme_is_https;
	assign status_is_ok = out_res.status_is_ok;
	assign present_mask = out_res.present_mask;
	assign path_start = out_res.path_start;
	assign path_length = out_res.path_length;
	assign authority_start = out_res.authority_start;
	assign authority_length = out_res.authority_length;
	assign origin_start = out_res.origin_start;
	assign origin_length = out_res.origin_length;

endmodule

FILE: rtl/core/lhbp_in_reg.sv
// input register stage, holds the final byte of a block while the result slot is busy
module lhbp_in_reg
	import lhbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  lhbp_item_t in_item,
	input  logic       out_busy,
	output logic       in_stall,
	output logic       take,
	output lhbp_item_t item_s1
);

	logic valid_s1;

	// a final byte may only be parsed when its result has somewhere to go
	assign take = valid_s1 && !(item_s1.last && out_busy);
	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/core/lhbp_parser.sv
// per byte parse state and next state logic, builds the result on the final byte
module lhbp_parser
	import lhbp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  lhbp_item_t   item,
	output logic         push,
	output lhbp_result_t res
);

	typedef enum logic [2:0] {
		PH_INSERT,
		PH_BASE,
		PH_PREFIX,
		PH_NAMELEN,
		PH_NAME,
		PH_VALLEN,
		PH_VALUE
	} phase_t;

	phase_t ph_q, ph_n;
	logic [2:0] vbl_q, vbl_n;
	logic [ACC_W-1:0] acc_q, acc_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [POS_W-1:0] fbl_q, fbl_n;
	logic [POS_W-1:0] nlen_q, nlen_n;
	logic [NUM_NAMES-1:0] nmv_q, nmv_n;
	logic [NUM_VALUES-1:0] vmv_q, vmv_n;
	logic [POS_W-1:0] vstart_q, vstart_n;
	logic err_q, err_n;
	logic [6:0] flag_q, flag_n;
	logic [OFF_W-1:0] cap_start_q [NUM_CAPS];
	logic [OFF_W-1:0] cap_start_n [NUM_CAPS];
	logic [LEN_W-1:0] cap_len_q [NUM_CAPS];
	logic [LEN_W-1:0] cap_len_n [NUM_CAPS];

	logic [7:0] b;
	logic [ACC_W+7:0] acc_wide;
	logic [POS_W-1:0] idx;
	logic [POS_W-1:0] fin_end;
	logic [POS_W-1:0] fin_len;
	logic fin;
	logic rej;

	assign b = item.block_byte;
	assign push = take && item.last;

	always_comb begin
		ph_n = ph_q;
		vbl_n = vbl_q;
		acc_n = acc_q;
		pos_n = pos_q;
		fbl_n = fbl_q;
		nlen_n = nlen_q;
		nmv_n = nmv_q;
		vmv_n = vmv_q;
		vstart_n = vstart_q;
		err_n = err_q;
		flag_n = flag_q;
		cap_start_n = cap_start_q;
		cap_len_n = cap_len_q;
		acc_wide = '0;
		idx = '0;
		fin = 1'b0;
		fin_end = '0;
		fin_len = '0;
		rej = 1'b0;
		res = '0;

		if (take) begin
			if (!err_q) begin
				if (pos_q >= POS_W'(MAX_BLOCK_BYTES)) begin
					err_n = 1'b1;
				end else begin
					unique case (ph_q)
						PH_PREFIX: begin
							if ((b & PREFIX_MASK) != PREFIX_CODE) begin
								err_n = 1'b1;
							end else begin
								ph_n = PH_NAMELEN;
								vbl_n = '0;
							end
						end
						PH_NAME: begin
							idx = nlen_q - fbl_q;
							for (int k = 0; k < NUM_NAMES; k++) begin
								if (!name_hit(k, idx, b)) nmv_n[k] = 1'b0;
							end
							fbl_n = fbl_q - 1'b1;
							if (fbl_n == '0) begin
								for (int k = 0; k < NUM_NAMES; k++) begin
									if (NAME_SIZE[k] != int'(nlen_q)) nmv_n[k] = 1'b0;
								end
								ph_n = PH_VALLEN;
								vbl_n = '0;
							end
						end
						PH_VALUE: begin
							idx = pos_q - vstart_q;
							for (int k = 0; k < NUM_VALUES; k++) begin
								if (!value_hit(k, idx, b)) vmv_n[k] = 1'b0;
							end
							fbl_n = fbl_q - 1'b1;
							if (fbl_n == '0) begin
								for (int k = 0; k < NUM_VALUES; k++) begin
									if (VALUE_SIZE[k] != int'(idx) + 1) vmv_n[k] = 1'b0;
								end
								fin = 1'b1;
								fin_end = pos_q + 1'b1;
							end
						end
						PH_INSERT, PH_BASE, PH_NAMELEN, PH_VALLEN: begin
							if (vbl_q == '0) begin
								// leading two bits give the varint length
								vbl_n = 3'((4'd1 << b[7:6]) - 4'd1);
								acc_n = ACC_W'(b & VARINT_MASK);
							end else begin
								acc_wide = {acc_q, b};
								if (acc_q > (ACC_CAP >> 8) || acc_wide > (ACC_W + 8)'(ACC_CAP)) begin
									acc_n = ACC_CAP;
								end else begin
									acc_n = acc_wide[ACC_W-1:0];
								end
								vbl_n = vbl_q - 1'b1;
							end
							if (vbl_n == '0) begin
								unique case (ph_q)
									PH_INSERT: begin
										if (acc_n != '0) err_n = 1'b1;
										ph_n = PH_BASE;
									end
									PH_BASE: begin
										if (acc_n != '0) err_n = 1'b1;
										ph_n = PH_PREFIX;
									end
									PH_NAMELEN: begin
										if (acc_n > ACC_W'(MAX_BLOCK_BYTES)) begin
											err_n = 1'b1;
										end else begin
											nlen_n = acc_n[POS_W-1:0];
											fbl_n = acc_n[POS_W-1:0];
											if (acc_n == '0) begin
												nmv_n = '0;
												ph_n = PH_VALLEN;
											end else begin
												nmv_n = '1;
												ph_n = PH_NAME;
											end
										end
									end
									default: begin
										if (acc_n > ACC_W'(MAX_BLOCK_BYTES)) begin
											err_n = 1'b1;
										end else begin
											vstart_n = pos_q + 1'b1;
											fbl_n = acc_n[POS_W-1:0];
											if (acc_n == '0) begin
												// no known value is empty
												vmv_n = '0;
												fin = 1'b1;
												fin_end = pos_q + 1'b1;
											end else begin
												vmv_n = '1;
												ph_n = PH_VALUE;
											end
										end
									end
								endcase
							end
						end
						default: begin
							err_n = 1'b1;
						end
					endcase

					if (fin) begin
						fin_len = fin_end - vstart_n;
						if (nmv_q[NM_METHOD] && vmv_n[VL_CONNECT]) flag_n[0] = 1'b1;
						if (nmv_q[NM_PROTOCOL] && vmv_n[VL_WEBTRANSPORT]) flag_n[1] = 1'b1;
						if (nmv_q[NM_SCHEME] && vmv_n[VL_HTTPS]) flag_n[2] = 1'b1;
						if (nmv_q[NM_STATUS] && vmv_n[VL_OK]) flag_n[3] = 1'b1;
						for (int k = 0; k < NUM_CAPS; k++) begin
							if (nmv_q[NM_PATH + k]) begin
								flag_n[4 + k] = 1'b1;
								cap_start_n[k] = vstart_n[OFF_W-1:0];
								cap_len_n[k] = LEN_W'(fin_len);
							end
						end
						ph_n = PH_PREFIX;
					end
				end
			end

			if (pos_q < POS_W'(MAX_BLOCK_BYTES)) pos_n = pos_q + 1'b1;

			if (item.last) begin
				rej = err_n || ph_n != PH_PREFIX;
				res.rejected = rej;
				if (!rej) begin
					res.method_is_connect = flag_n[0];
					res.protocol_is_webtransport = flag_n[1];
					res.scheme_is_https = flag_n[2];
					res.status_is_ok = flag_n[3];
					res.present_mask = flag_n[6:4];
					res.path_start = cap_start_n[0];
					res.path_length = cap_len_n[0];
					res.authority_start = cap_start_n[1];
					res.authority_length = cap_len_n[1];
					res.origin_start = cap_start_n[2];
					res.origin_length = cap_len_n[2];
				end
				// back to the start of a block
				ph_n = PH_INSERT;
				vbl_n = '0;
				acc_n = '0;
				pos_n = '0;
				fbl_n = '0;
				nlen_n = '0;
				nmv_n = '1;
				vmv_n = '1;
				vstart_n = '0;
				err_n = 1'b0;
				flag_n = '0;
				for (int k = 0; k < NUM_CAPS; k++) begin
					cap_start_n[k] = '0;
					cap_len_n[k] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_INSERT;
			vbl_q <= '0;
			acc_q <= '0;
			pos_q <= '0;
			fbl_q <= '0;
			nlen_q <= '0;
			nmv_q <= '1;
			vmv_q <= '1;
			vstart_q <= '0;
			err_q <= 1'b0;
			flag_q <= '0;
			for (int k = 0; k < NUM_CAPS; k++) begin
				cap_start_q[k] <= '0;
				cap_len_q[k] <= '0;
			end
		end else begin
			ph_q <= ph_n;
			vbl_q <= vbl_n;
			acc_q <= acc_n;
			pos_q <= pos_n;
			fbl_q <= fbl_n;
			nlen_q <= nlen_n;
			nmv_q <= nmv_n;
			vmv_q <= vmv_n;
			vstart_q <= vstart_n;
			err_q <= err_n;
			flag_q <= flag_n;
			cap_start_q <= cap_start_n;
			cap_len_q <= cap_len_n;
		end
	end

`ifndef SYNTH
	a_rej_clears_fields: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.rejected |-> res.present_mask == '0 && !res.method_is_connect
			&& !res.protocol_is_webtransport && !res.scheme_is_https && !res.status_is_ok)
		else $error("rejected block carries flags");
	a_restart_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> pos_q == '0 && ph_q == PH_INSERT && !err_q && flag_q == '0)
		else $error("parser not back at block start after result");
	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_BLOCK_BYTES) && vstart_q <= POS_W'(MAX_BLOCK_BYTES))
		else $error("byte position out of range");
	a_present_has_capture: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_VALUE && !err_q |-> fbl_q != '0)
		else $error("value phase with no bytes left");
`endif

endmodule

FILE: rtl/core/lhbp_out_reg.sv
// result register toward the receiver
module lhbp_out_reg
	import lhbp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  lhbp_result_t res,
	input  logic         out_stall,
	output logic         out_valid,
	output logic         out_busy,
	output lhbp_result_t out_res
);

	logic valid_q;
	lhbp_result_t res_q;

	// a push only comes when the slot is free or being drained this cycle
	assign out_busy = valid_q && out_stall;
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= out_busy || push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

endmodule
